// ===== design/mca_pkg.sv =====
// ----------------------------------------------------------------------------
// mca_pkg
// Shared types and constants for the menu cursor autorepeat block: cursor
// action codes, button positions, configuration register map and values.
// ----------------------------------------------------------------------------
`default_nettype none

package mca_pkg;

  // width of the sampled button vector and of the time stamps
  localparam int unsigned BUTTON_BITS = 16;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned ADDR_BITS   = 3;
  localparam int unsigned DATA_BITS   = 32;

  // button positions in the sampled vector
  localparam int unsigned BtnLeft   = 0;
  localparam int unsigned BtnRight  = 1;
  localparam int unsigned BtnUp     = 2;
  localparam int unsigned BtnDown   = 3;
  localparam int unsigned BtnStart  = 4;
  localparam int unsigned BtnCircle = 5;
  localparam int unsigned BtnCross  = 6;
  localparam int unsigned BtnSquare = 7;

  // cursor action codes
  typedef enum logic [2:0] {
    ActNone   = 3'd0,
    ActLeft   = 3'd1,
    ActRight  = 3'd2,
    ActUp     = 3'd3,
    ActDown   = 3'd4,
    ActSelect = 3'd5,
    ActExit   = 3'd6,
    ActBack   = 3'd7
  } action_e;

  // register index, taken from address bit 2 (registers at 0x0 and 0x4)
  localparam logic RegInitialDelay   = 1'b0;
  localparam logic RegRepeatInterval = 1'b1;

  // register reset values in microseconds
  localparam logic [TIME_BITS-1:0] INITIAL_DELAY_RESET   = 32'd200000;
  localparam logic [TIME_BITS-1:0] REPEAT_INTERVAL_RESET = 32'd50000;

  // configuration seen by the datapath
  typedef struct packed {
    logic [TIME_BITS-1:0] initial_delay_us;
    logic [TIME_BITS-1:0] repeat_interval_us;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/mca_regs.sv =====
// ----------------------------------------------------------------------------
// mca_regs
// APB-style register file holding the first-repeat delay and the repeat
// interval. Zero wait states; reads return the stored values.
// ----------------------------------------------------------------------------
`default_nettype none

module mca_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mca_pkg::ADDR_BITS-1:0]  paddr,
  input  wire logic [mca_pkg::DATA_BITS-1:0]  pwdata,
  output logic      [mca_pkg::DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output mca_pkg::cfg_t                       cfg_o
);
  import mca_pkg::*;

  logic [TIME_BITS-1:0] initial_delay_q;
  logic [TIME_BITS-1:0] repeat_interval_q;
  logic                 wr_en;
  logic                 reg_sel;

  // no wait states
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_delay_q   <= INITIAL_DELAY_RESET;
      repeat_interval_q <= REPEAT_INTERVAL_RESET;
    end else if (wr_en) begin
      if (reg_sel == RegInitialDelay) begin
        initial_delay_q <= pwdata;
      end else begin
        repeat_interval_q <= pwdata;
      end
    end
  end

  // read back
  always_comb begin
    if (reg_sel == RegInitialDelay) begin
      prdata = initial_delay_q;
    end else begin
      prdata = repeat_interval_q;
    end
  end

  assign cfg_o.initial_delay_us   = initial_delay_q;
  assign cfg_o.repeat_interval_us = repeat_interval_q;

endmodule

`default_nettype wire

// ===== design/menu_cursor_autorepeat.sv =====
// ----------------------------------------------------------------------------
// menu_cursor_autorepeat
// Turns polled button samples into cursor actions with typematic repeat.
// ----------------------------------------------------------------------------
// One result beat per input beat. A sample is taken in any cycle in which the
// result register is empty or being drained, so a new sample can follow in
// every cycle; its action appears on the output in the cycle after acceptance.
// The input stalls only while the result register holds a beat and the
// output side stalls. Newly pressed buttons (held now, not held in the
// previous sample) are priority encoded: square (back) over cross (exit)
// over circle or start (select) over down, up, right, left. While any button
// of the last pressed set stays held, the action repeats once the hold time
// strictly exceeds initial_delay_us (reg 0x0), then each time it strictly
// exceeds repeat_interval_us (reg 0x4). Hold time is the wrapping 32-bit
// difference of now_us against the last press or repeat.
// ----------------------------------------------------------------------------
`default_nettype none

module menu_cursor_autorepeat (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // sample channel
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [mca_pkg::BUTTON_BITS-1:0]  buttons_i,
  input  wire logic [mca_pkg::TIME_BITS-1:0]    now_us_i,
  // action channel
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [2:0]                       cursor_action_o,
  // configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mca_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [mca_pkg::DATA_BITS-1:0]    pwdata,
  output logic      [mca_pkg::DATA_BITS-1:0]    prdata,
  output logic                                  pready
);
  import mca_pkg::*;

  typedef enum logic [1:0] {
    PhaseIdle   = 2'd0,
    PhaseFirst  = 2'd1,
    PhaseRepeat = 2'd2
  } phase_e;

  cfg_t                   cfg;
  logic                   in_accept;

  logic [BUTTON_BITS-1:0] prev_q;
  logic [TIME_BITS-1:0]   start_q, start_d;
  phase_e                 phase_q, phase_d;
  logic [BUTTON_BITS-1:0] rep_set_q, rep_set_d;
  action_e                rep_act_q, rep_act_d;
  logic                   out_valid_q;
  action_e                action_q, action_d;

  logic [BUTTON_BITS-1:0] fresh;
  action_e                new_act;
  logic [TIME_BITS-1:0]   elapsed;
  logic                   keep_alive;
  logic                   fire_first;
  logic                   fire_repeat;

  // priority encoder over the newly pressed action buttons
  function automatic action_e encode_action(input logic [BUTTON_BITS-1:0] f);
    action_e a;
    if (f[BtnSquare]) begin
      a = ActBack;
    end else if (f[BtnCross]) begin
      a = ActExit;
    end else if (f[BtnCircle] || f[BtnStart]) begin
      a = ActSelect;
    end else if (f[BtnDown]) begin
      a = ActDown;
    end else if (f[BtnUp]) begin
      a = ActUp;
    end else if (f[BtnRight]) begin
      a = ActRight;
    end else if (f[BtnLeft]) begin
      a = ActLeft;
    end else begin
      a = ActNone;
    end
    return a;
  endfunction

  mca_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake: result register frees up when empty or drained
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign cursor_action_o = action_q;

  // edge detect, hold timer and repeat checks
  assign fresh      = buttons_i & ~prev_q;
  assign new_act    = encode_action(fresh);
  assign elapsed    = now_us_i - start_q;
  assign keep_alive = |(buttons_i & rep_set_q);
  assign fire_first  = (phase_q == PhaseFirst) && (elapsed > cfg.initial_delay_us);
  assign fire_repeat = (phase_q == PhaseRepeat) && (elapsed > cfg.repeat_interval_us);

  // next state and action for the accepted sample
  always_comb begin
    start_d   = start_q;
    phase_d   = phase_q;
    rep_set_d = rep_set_q;
    rep_act_d = rep_act_q;
    action_d  = new_act;
    if (new_act != ActNone) begin
      start_d   = now_us_i;
      phase_d   = PhaseFirst;
      rep_set_d = fresh;
      rep_act_d = new_act;
    end else if (keep_alive && (fire_first || fire_repeat)) begin
      // the timer restarts, so the first repeat cannot also fire an interval
      action_d = rep_act_q;
      start_d  = now_us_i;
      phase_d  = PhaseRepeat;
    end
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      start_q     <= '0;
      phase_q     <= PhaseIdle;
      rep_set_q   <= '0;
      rep_act_q   <= ActNone;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        prev_q      <= buttons_i;
        start_q     <= start_d;
        phase_q     <= phase_d;
        rep_set_q   <= rep_set_d;
        rep_act_q   <= rep_act_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      action_q <= action_d;
    end
  end

  // input only stalls behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty result register");

  // an accepted sample always yields a result beat next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted sample produced no result beat");

  // a fresh press is reported as its encoded action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (new_act != ActNone)) |=> (cursor_action_o == $past(new_act)))
    else $error("new press not reported");

  // once armed, the repeat action is always a real action
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhaseIdle) |-> (rep_act_q != ActNone))
    else $error("repeat armed without an action");

  // a repeat is only taken with a button of the repeat set held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (new_act == ActNone) && (action_d != ActNone)) |-> keep_alive)
    else $error("repeat fired with repeat set released");

endmodule

`default_nettype wire

// ===== tb/menu_cursor_autorepeat_test.sv =====
// ----------------------------------------------------------------------------
// menu_cursor_autorepeat_test
// Self-checking bench for the cursor autorepeat block. Polls are queued by
// the sequencer and offered by a clocked driver with random gaps. Each
// accepted poll runs through a local typematic model whose predicted action
// is queued. A clocked monitor with random stall compares every action beat
// against that queue. Timing registers are rewritten over the APB port
// between phases while the block is drained.
// ----------------------------------------------------------------------------

module menu_cursor_autorepeat_test;

  timeunit 1ns;
  timeprecision 1ps;

  import mca_pkg::*;

  localparam int unsigned IDLE_PCT    = 23;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef enum logic [1:0] {
    PhaseNotHeld = 2'd0,
    PhaseFirst   = 2'd1,
    PhaseRepeat  = 2'd2
  } hold_phase_e;

  typedef struct packed {
    logic [BUTTON_BITS-1:0] buttons;
    logic [TIME_BITS-1:0]   now_us;
  } poll_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  // block ports
  logic                   in_valid_i      = 1'b0;
  logic                   in_stall_o;
  logic [BUTTON_BITS-1:0] buttons_i       = '0;
  logic [TIME_BITS-1:0]   now_us_i        = '0;
  logic                   out_valid_o;
  logic                   out_stall_i     = 1'b0;
  logic [2:0]             cursor_action_o;
  logic                   psel            = 1'b0;
  logic                   penable         = 1'b0;
  logic                   pwrite          = 1'b0;
  logic [ADDR_BITS-1:0]   paddr           = '0;
  logic [DATA_BITS-1:0]   pwdata          = '0;
  logic [DATA_BITS-1:0]   prdata;
  logic                   pready;

  menu_cursor_autorepeat DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .buttons_i       (buttons_i),
    .now_us_i        (now_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cursor_action_o (cursor_action_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // bench state
  poll_t       pending_polls[$];
  action_e     expected_actions[$];
  int unsigned mismatches     = 0;
  int unsigned cycles         = 0;
  int unsigned long_hold_reqs = 0;
  int unsigned long_hold_seen = 0;
  int unsigned long_hold_left = 0;
  bit          steady_mode    = 1'b0;
  logic [TIME_BITS-1:0] poll_clock = '0;

  // typematic model state and its copy of the registers
  logic [BUTTON_BITS-1:0] last_held   = '0;
  logic [TIME_BITS-1:0]   hold_since  = '0;
  hold_phase_e            hold_phase  = PhaseNotHeld;
  logic [BUTTON_BITS-1:0] repeat_set  = '0;
  action_e                repeat_act  = ActNone;
  logic [TIME_BITS-1:0]   delay_first = INITIAL_DELAY_RESET;
  logic [TIME_BITS-1:0]   delay_next  = REPEAT_INTERVAL_RESET;

  // priority encode the fresh presses, then advance the hold timer
  function automatic action_e next_cursor_action(input logic [BUTTON_BITS-1:0] held,
                                                 input logic [TIME_BITS-1:0] now);
    logic [BUTTON_BITS-1:0] fresh;
    logic [TIME_BITS-1:0]   elapsed;
    action_e                act;
    fresh = ~last_held & held;
    if (fresh[BtnSquare])                         act = ActBack;
    else if (fresh[BtnCross])                     act = ActExit;
    else if (fresh[BtnCircle] || fresh[BtnStart]) act = ActSelect;
    else if (fresh[BtnDown])                      act = ActDown;
    else if (fresh[BtnUp])                        act = ActUp;
    else if (fresh[BtnRight])                     act = ActRight;
    else if (fresh[BtnLeft])                      act = ActLeft;
    else                                          act = ActNone;
    last_held = held;
    if (act != ActNone) begin
      hold_since = now;
      hold_phase = PhaseFirst;
      repeat_set = fresh;
      repeat_act = act;
    end else if ((held & repeat_set) != '0) begin
      elapsed = now - hold_since;
      if (hold_phase == PhaseFirst && elapsed > delay_first) begin
        act        = repeat_act;
        hold_since = now;
        hold_phase = PhaseRepeat;
      end
      // timer restarted above, so the interval cannot also fire here
      elapsed = now - hold_since;
      if (hold_phase == PhaseRepeat && elapsed > delay_next) begin
        act        = repeat_act;
        hold_since = now;
      end
    end
    return act;
  endfunction

  // poll driver
  always @(posedge clk_i) begin : drive_polls
    poll_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_actions.push_back(next_cursor_action(buttons_i, now_us_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_polls.size() != 0 &&
            (steady_mode || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_polls.pop_front();
          in_valid_i <= 1'b1;
          buttons_i  <= nxt.buttons;
          now_us_i   <= nxt.now_us;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
      out_stall_i    <= 1'b1;
    end else if (long_hold_seen != long_hold_reqs) begin
      long_hold_seen <= long_hold_reqs;
      long_hold_left <= LONG_HOLD;
      out_stall_i    <= 1'b1;
    end else begin
      out_stall_i <= !steady_mode && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_SHOWN) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // action monitor
  always @(posedge clk_i) begin : watch_actions
    action_e want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_actions.size() == 0) begin
        flag_mismatch($sformatf("action beat %0d with nothing expected", cursor_action_o));
      end else begin
        want = expected_actions.pop_front();
        if (cursor_action_o !== want)
          flag_mismatch($sformatf("cursor_action expected %0d got %0d",
                                  want, cursor_action_o));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // register write: setup then access beat
  task automatic write_reg(input logic idx, input logic [DATA_BITS-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegInitialDelay:   delay_first = value;
      RegRepeatInterval: delay_next  = value;
      default: ;
    endcase
  endtask

  task automatic push_poll(input logic [BUTTON_BITS-1:0] b, input logic [TIME_BITS-1:0] t);
    pending_polls.push_back('{buttons: b, now_us: t});
  endtask

  // wait until every poll is taken and every action has come back
  task automatic wait_drained();
    while (pending_polls.size() != 0 || in_valid_i || expected_actions.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly press, hold and release runs on a running clock, some noise
  task automatic add_sequences(input logic [TIME_BITS-1:0] step_max, input int unsigned count);
    int unsigned            queued;
    int unsigned            hold_len;
    logic [7:0]             act_bits;
    logic [7:0]             other_bits;
    logic [BUTTON_BITS-1:0] b;
    logic [31:0]            r;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(99) < 15) begin
        r = $urandom;
        push_poll(r[15:0], $urandom);
        queued++;
      end else begin
        r          = $urandom;
        act_bits   = r[7:0];
        if (r[8] || act_bits == 8'h00) act_bits = 8'h01 << $urandom_range(7);
        other_bits = (r[10:9] == 2'b00) ? r[23:16] : 8'h00;
        hold_len   = $urandom_range(25, 2);
        repeat (hold_len) begin
          poll_clock = poll_clock + $urandom_range(step_max);
          b          = {other_bits, act_bits};
          // partial release of the action buttons now and then
          if ($urandom_range(9) == 0) b[7:0] = act_bits & 8'($urandom);
          push_poll(b, poll_clock);
          queued++;
        end
        poll_clock = poll_clock + $urandom_range(step_max);
        push_poll({($urandom_range(3) == 0) ? other_bits : 8'h00, 8'h00}, poll_clock);
        queued++;
      end
    end
  endtask

  task automatic run_phase(input logic [TIME_BITS-1:0] first_us,
                           input logic [TIME_BITS-1:0] next_us,
                           input logic [TIME_BITS-1:0] step_max,
                           input int unsigned count, input bit steady, input bit squeeze);
    write_reg(RegInitialDelay, first_us);
    write_reg(RegRepeatInterval, next_us);
    steady_mode = steady;
    poll_clock  = $urandom;
    if (squeeze) begin
      add_sequences(step_max, count / 2);
      long_hold_reqs++;
      // sender waits for every action before going on
      wait_drained();
      add_sequences(step_max, count - count / 2);
    end else begin
      add_sequences(step_max, count);
    end
    wait_drained();
    steady_mode = 1'b0;
  endtask

  // sequencer
  initial begin : sequencer
    logic [TIME_BITS-1:0] t;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: each action button pressed on top of the ones before
    push_poll(16'h0000, 32'h0000_0000);
    for (int i = 0; i < 8; i++) push_poll(16'((2 << i) - 1), 32'(100 + 10 * i));
    push_poll(16'h0000, 32'd200);
    // other buttons alone give nothing, all at once gives back
    push_poll(16'hFF00, 32'd300);
    push_poll(16'hFFFF, 32'd400);
    push_poll(16'h0000, 32'd500);
    push_poll(16'h0030, 32'd600);
    push_poll(16'h0000, 32'd700);
    // other button pressed with left keeps the repeat going
    t = 32'd1000;
    push_poll(16'h0101, t);
    t = t + INITIAL_DELAY_RESET + 1;
    push_poll(16'h0100, t);
    t = t + REPEAT_INTERVAL_RESET + 1;
    push_poll(16'h0100, t);
    t = t + REPEAT_INTERVAL_RESET;
    push_poll(16'h0100, t);
    // release pauses the repeat, holding again resumes it
    push_poll(16'h0000, t + 10);
    t = t + 32'd1000000;
    push_poll(16'h0000, t);
    push_poll(16'h0100, t + 10);
    // a long jump gives only the first repeat
    push_poll(16'h0008, t + 20);
    push_poll(16'h0008, t + 20 + 32'd300000);
    // wrap of the time stamp
    push_poll(16'h0000, 32'hFFFF_FFE0);
    push_poll(16'h0004, 32'hFFFF_FFF0);
    push_poll(16'h0004, 32'h0003_0D50);
    push_poll(16'hFFFF, 32'hFFFF_FFFF);
    wait_drained();

    // random phases over several timing settings
    run_phase(INITIAL_DELAY_RESET, REPEAT_INTERVAL_RESET, 32'd30000, 150, 1'b0, 1'b0);
    run_phase(32'd0, 32'd0, 32'd2, 130, 1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 1'b0, 1'b0);
    run_phase(32'd1000, 32'd300, 32'd400, 140, 1'b1, 1'b0);
    run_phase(32'd300, 32'hFFFF_FFFF, 32'd200, 110, 1'b0, 1'b0);
    run_phase($urandom_range(5000), $urandom_range(2000), 32'd800, 150, 1'b0, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_actions.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
